### src/bdcd_pkg.sv
// shared types, widths and codes for the double-click detector
package bdcd_pkg;

	localparam int MAX_BUTTONS_DEF = 32;
	localparam int BTN_W           = 32;
	localparam int TIME_W          = 31;
	localparam int DL_W            = 32;
	localparam int WIN_W           = 16;
	localparam int USE_W           = 6;
	localparam int CFG_IDX_W       = 1;
	localparam int IN_DATA_W       = 64;
	localparam int OUT_DATA_W      = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS = 1'b1;

	localparam logic [WIN_W-1:0] WIN_RESET = 16'd19;
	localparam logic [USE_W-1:0] USE_RESET = 6'd32;

	// per-button click count codes
	localparam logic [1:0] CNT_IDLE   = 2'd0;
	localparam logic [1:0] CNT_FIRST  = 2'd1;
	localparam logic [1:0] CNT_DOUBLE = 2'd2;

	typedef struct packed {
		logic pressed;
		logic dbl;
	} lane_res_t;

endpackage

### src/button_double_click_detector_unit.sv
// top level of the button double-click detector
//
// channel  | dir | payload (tdata, low bit first)              | notes
// s_*      | in  | button_bits[31:0], now_time[62:32], 0 [63]   | one poll per transaction
// m_*      | out | pressed_bits[31:0], double_bits[63:32]       | one result per poll
// cfg_*    | in  | cfg_index selects window or buttons in use   | write only, taken at once
//
// a poll is latched into the input stage, all lanes evaluate and commit once the
// output slot is free, and the result sits in the output register; one poll per
// cycle is sustained while the output is taken
// lanes are one per button; each holds its own state in flip-flops
// reset clears all button state, sets the window to 19 ticks and uses all buttons
// a stalled output holds the staged poll, which in turn holds off s_tready
module button_double_click_detector_unit #(
	parameter int MAX_BUTTONS = bdcd_pkg::MAX_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bdcd_pkg::IN_DATA_W-1:0]      s_tdata,   // button_bits, now_time
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bdcd_pkg::OUT_DATA_W-1:0]     m_tdata,   // pressed_bits, double_bits
	input  logic                                cfg_we,
	input  logic [bdcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bdcd_pkg::WIN_W-1:0]          cfg_data
);
	import bdcd_pkg::*;

	// configuration registers
	logic [WIN_W-1:0]  window_q;
	logic [USE_W-1:0]  use_q;

	// input stage
	logic              valid_s1;
	logic [BTN_W-1:0]  bits_s1;
	logic [TIME_W-1:0] now_s1;

	logic              free;
	logic              commit;
	logic [MAX_BUTTONS-1:0] lane_use;
	lane_res_t         res [MAX_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
			use_q    <= USE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW: begin
					window_q <= cfg_data;
				end
				CFG_BUTTONS: begin
					use_q <= cfg_data[USE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// the staged poll moves into the lanes once the output slot is free
	assign commit   = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bits_s1 <= s_tdata[BTN_W-1:0];
			now_s1  <= s_tdata[BTN_W +: TIME_W];
		end
	end

	// one lane per button; a lane at or above buttons in use is left alone
	for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_lane
		assign lane_use[i] = USE_W'(i) < use_q;

		bdcd_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.commit   (commit),
			.in_use   (lane_use[i]),
			.level    (bits_s1[i]),
			.now_time (now_s1),
			.window   (window_q),
			.res      (res[i])
		);
	end

	bdcd_merge #(
		.NUM_LANES (MAX_BUTTONS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	a_dbl_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:BTN_W] & ~m_tdata[BTN_W-1:0]) == '0)
		else $error("double bit set on a released button");
	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("output appeared without a staged poll");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !free |=> valid_s1 && $stable(bits_s1) && $stable(now_s1))
		else $error("staged poll lost during output stall");
`endif

endmodule

### src/bdcd_lane.sv
// one button lane: held flag, click count, deadline and result bits
module bdcd_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              commit,
	input  logic                              in_use,
	input  logic                              level,
	input  logic [bdcd_pkg::TIME_W-1:0]       now_time,
	input  logic [bdcd_pkg::WIN_W-1:0]        window,
	output bdcd_pkg::lane_res_t               res
);
	import bdcd_pkg::*;

	logic             held_q;
	logic [1:0]       cnt_q;
	logic [DL_W-1:0]  deadline_q;
	logic [DL_W-1:0]  now_ext;
	logic             late;
	logic             early;
	logic             restart;
	logic             second;

	assign now_ext = {1'b0, now_time};
	assign late    = now_ext > deadline_q;
	assign early   = now_ext < deadline_q;
	// new press: restart the window, or a second press inside it
	assign restart = (cnt_q == CNT_IDLE) || late;
	assign second  = !restart && early;

	assign res.pressed = in_use && level;
	assign res.dbl     = in_use && level && ((!held_q && second) ||
		(held_q && cnt_q == CNT_DOUBLE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 1'b0;
			cnt_q      <= CNT_IDLE;
			deadline_q <= '0;
		end else if (commit && in_use) begin
			if (level) begin
				held_q <= 1'b1;
				if (!held_q) begin
					if (restart) begin
						deadline_q <= now_ext + {{(DL_W-WIN_W){1'b0}}, window};
						cnt_q      <= CNT_FIRST;
					end else if (early) begin
						deadline_q <= '0;
						cnt_q      <= CNT_DOUBLE;
					end
				end
			end else begin
				held_q <= 1'b0;
				if (cnt_q == CNT_DOUBLE) begin
					cnt_q <= CNT_IDLE;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_code: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_IDLE || cnt_q == CNT_FIRST || cnt_q == CNT_DOUBLE)
		else $error("lane click count holds an unused code");
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		commit && in_use && !level |=> !held_q && cnt_q != CNT_DOUBLE)
		else $error("lane not cleared after release");
	a_double_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		commit && in_use && res.dbl && !held_q |=> deadline_q == '0 && cnt_q == CNT_DOUBLE)
		else $error("double click did not clear the deadline");
`endif

endmodule

### src/bdcd_merge.sv
// gathers lane results into the output vectors and holds the output transaction
module bdcd_merge #(
	parameter int NUM_LANES = bdcd_pkg::MAX_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                commit,
	input  bdcd_pkg::lane_res_t                 res [NUM_LANES],
	output logic                                free,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bdcd_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import bdcd_pkg::*;

	logic [BTN_W-1:0] pressed_vec;
	logic [BTN_W-1:0] dbl_vec;
	logic             valid_q;
	logic [BTN_W-1:0] pressed_q;
	logic [BTN_W-1:0] dbl_q;

	always_comb begin
		pressed_vec = '0;
		dbl_vec     = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			pressed_vec[i] = res[i].pressed;
			dbl_vec[i]     = res[i].dbl;
		end
	end

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (commit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			pressed_q <= pressed_vec;
			dbl_q     <= dbl_vec;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {dbl_q, pressed_q};

endmodule

### bench/testbench.sv
// self-checking bench for the button double-click detector: directed and random polls
`timescale 1ns / 1ps

module testbench;
	import bdcd_pkg::*;

	// tracks per-button click state and holds the results still owed by the block
	class click_tracker;
		logic [WIN_W-1:0] window;
		logic [USE_W-1:0] in_use;
		bit               held     [MAX_BUTTONS_DEF];
		logic [DL_W-1:0]  deadline [MAX_BUTTONS_DEF];
		logic [1:0]       count    [MAX_BUTTONS_DEF];
		logic [OUT_DATA_W-1:0] owed_results [$];
		int unsigned      errors;

		function new();
			window = WIN_RESET;
			in_use = USE_RESET;
			errors = 0;
			for (int i = 0; i < MAX_BUTTONS_DEF; i++) begin
				held[i]     = 1'b0;
				deadline[i] = '0;
				count[i]    = CNT_IDLE;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] value);
			if (idx == CFG_WINDOW) begin
				window = value;
			end else if (idx == CFG_BUTTONS) begin
				in_use = value[USE_W-1:0];
			end
		endfunction

		// one accepted poll: step every button in use and queue the owed result
		function void note_poll(logic [BTN_W-1:0] bits, logic [TIME_W-1:0] now);
			logic [BTN_W-1:0] pressed;
			logic [BTN_W-1:0] dbl;
			logic [DL_W-1:0]  now_ext;
			int unsigned      lanes;
			pressed = '0;
			dbl     = '0;
			now_ext = {1'b0, now};
			lanes   = (in_use > MAX_BUTTONS_DEF) ? MAX_BUTTONS_DEF : in_use;
			for (int unsigned i = 0; i < lanes; i++) begin
				if (bits[i]) begin
					pressed[i] = 1'b1;
					if (!held[i]) begin
						held[i] = 1'b1;
						if (count[i] == CNT_IDLE || now_ext > deadline[i]) begin
							deadline[i] = now_ext + {16'b0, window};
							count[i]    = CNT_FIRST;
						end else if (now_ext < deadline[i]) begin
							dbl[i]      = 1'b1;
							deadline[i] = '0;
							count[i]    = CNT_DOUBLE;
						end
					end else if (count[i] == CNT_DOUBLE) begin
						dbl[i] = 1'b1;
					end
				end else begin
					if (count[i] == CNT_DOUBLE)
						count[i] = CNT_IDLE;
					held[i] = 1'b0;
				end
			end
			owed_results.push_back({dbl, pressed});
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			logic [OUT_DATA_W-1:0] want;
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, data);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (data[31:0] !== want[31:0]) begin
				$display("%0t: pressed_bits expected %h actual %h", $time, want[31:0],
					data[31:0]);
				errors++;
			end
			if (data[63:32] !== want[63:32]) begin
				$display("%0t: double_bits expected %h actual %h", $time, want[63:32],
					data[63:32]);
				errors++;
			end
		endfunction

		function int unsigned waiting();
			return owed_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;    // button_bits, now_time
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // pressed_bits, double_bits
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [WIN_W-1:0]      cfg_data;

	click_tracker tracker = new();

	// random idling on both sides, switched off for a stretch of the run
	bit idle_enable = 1'b1;
	// raised by the stimulus to make the receiver hold off for a long stretch
	bit hold_request = 1'b0;

	// running button levels and time of the well-formed random sequences
	logic [BTN_W-1:0]  levels = '0;
	logic [TIME_W-1:0] tick   = '0;

	button_double_click_detector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// offer one poll, starting and ending at a falling edge, with random gaps ahead of it
	task automatic send_poll(input logic [BTN_W-1:0] bits, input logic [TIME_W-1:0] now);
		while (idle_enable && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, now, bits};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// transaction taken at this edge
		tracker.note_poll(bits, now);
		@(negedge clk);
	endtask

	// register write, then cfg_we is dropped before returning so two writes never overlap in one step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		tracker.write_reg(idx, value);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering and wait for every owed result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.waiting() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_regs(input logic [WIN_W-1:0] window, input logic [WIN_W-1:0] in_use);
		settle();
		write_reg(CFG_WINDOW, window);
		write_reg(CFG_BUTTONS, in_use);
	endtask

	// mostly well-formed click sequences: sparse button toggles and small time steps,
	// with occasional jumps to a fresh random time and some pure noise
	task automatic play_random(input int unsigned count, input bit with_hold);
		int unsigned pick;
		for (int unsigned n = 0; n < count; n++) begin
			if (with_hold && n == count / 2)
				hold_request = 1'b1;
			pick = $urandom_range(99);
			if (pick < 82) begin
				levels = levels ^ ($urandom & $urandom & $urandom);
				tick   = TIME_W'(tick + (($urandom_range(9) == 0) ?
					$urandom_range(60) : $urandom_range(6)));
				send_poll(levels, tick);
			end else if (pick < 92) begin
				levels = $urandom;
				tick   = TIME_W'($urandom);
				send_poll(levels, tick);
			end else begin
				send_poll($urandom, TIME_W'($urandom));
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off counted here while polls keep coming
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			m_tready <= (idle_enable && $urandom_range(99) < 6) ? 1'b0 : 1'b1;
		end
	end

	// every result transaction is checked at the edge that takes it
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// main stimulus
	initial begin
		logic [WIN_W-1:0] win_sel;
		logic [WIN_W-1:0] use_sel;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed polls under reset settings (window 19, all buttons)
		send_poll(32'h0000_0000, 31'd0);
		send_poll(32'hFFFF_FFFF, 31'd0);           // first click on every button
		send_poll(32'h0000_0000, 31'd5);
		send_poll(32'hFFFF_FFFF, 31'd10);          // second press inside the window
		send_poll(32'hFFFF_FFFF, 31'd11);          // held after a double click
		send_poll(32'h0000_0000, 31'd12);          // release drops the double state
		send_poll(32'hAAAA_AAAA, 31'd100);         // deadline 119
		send_poll(32'h0000_0000, 31'd110);
		send_poll(32'hAAAA_AAAA, 31'd119);         // press right on the deadline
		send_poll(32'h0000_0000, 31'd120);
		send_poll(32'hAAAA_AAAA, 31'd121);         // after the deadline: new first click
		send_poll(32'h5555_5555, 31'd122);
		send_poll(32'h0000_0000, 31'd123);
		send_poll(32'hFFFF_FFFF, 31'd130);         // both halves double clicked
		send_poll(32'h0000_0000, 31'd131);
		send_poll(32'h8000_0001, 31'h7FFF_FFF0);   // deadline beyond 31 bits
		send_poll(32'h0000_0000, 31'h7FFF_FFF8);
		send_poll(32'h8000_0001, 31'h7FFF_FFFF);
		send_poll(32'h0000_0000, 31'h7FFF_FFFF);
		send_poll(32'h0000_0001, 31'd0);           // time going backwards
		send_poll(32'h0000_0000, 31'd0);
		send_poll(32'h0000_0001, 31'd3);
		send_poll(32'h0000_0000, 31'd3);

		// random phases over a spread of settings, extremes first
		for (int p = 0; p < 11; p++) begin
			case (p)
				0: begin win_sel = 16'd19;    use_sel = 16'd32; end
				1: begin win_sel = 16'd1;     use_sel = 16'd32; end
				2: begin win_sel = 16'd0;     use_sel = 16'd7;  end
				3: begin win_sel = 16'hFFFF;  use_sel = 16'd32; end
				4: begin win_sel = 16'd3;     use_sel = 16'd0;  end
				5: begin win_sel = 16'd40;    use_sel = 16'd33; end
				6: begin win_sel = 16'd12;    use_sel = 16'd63; end
				7: begin win_sel = 16'd25;    use_sel = 16'd1;  end
				default: begin
					win_sel = WIN_W'(($urandom_range(3) == 0) ? $urandom :
						$urandom_range(1, 40));
					use_sel = ($urandom_range(1) == 0) ? 16'd32 :
						WIN_W'($urandom_range(0, 63));
				end
			endcase
			set_regs(win_sel, use_sel);
			// no random idling on either side for two phases
			idle_enable = !(p == 5 || p == 6);
			play_random(100, p == 2);
		end

		// drain and judge
		settle();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
